// ===== rtl/core/dtr_pkg.sv =====
// shared types and constants of the depth tested triangle rasterizer
package dtr_pkg;

    localparam int CW = 13;
    localparam int DW = 14;
    localparam int EW = 2 * DW;
    localparam int ZW = 16;
    localparam int PW = ZW + EW;
    localparam int NW = PW + 2;
    localparam int QW = 18;
    localparam int BW = 8;
    localparam int CNTW = 13;
    localparam int VW = 27;

    localparam int BRIGHT_GAIN = 255;
    localparam int BRIGHT_OFS = 20 * 16384;
    localparam int FRAC_BITS = 14;

    localparam logic [1:0] FUNC_DRAW = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_WDEPTH = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [CNTW-1:0] CNT_MAX = {CNTW{1'b1}};

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_BOX, ST_AREA, ST_EA, ST_EB, ST_EG, ST_ORG,
        ST_SCAN, ST_MUL, ST_DIV, ST_WB, ST_RD, ST_RDW, ST_WR, ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic signed [NW-1:0] num;
        logic signed [EW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic signed [QW:0]   quo;
    } t_div_rsp;

endpackage

// ===== rtl/core/dtr_ram.sv =====
// generic single port ram with registered read
module dtr_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    input  logic [DATA_W-1:0]          i_wdata,
    output logic [DATA_W-1:0]          o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/dtr_div.sv =====
// iterative restoring divider for depth interpolation, truncating toward zero
module dtr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtr_pkg::t_div_req i_req,
    output dtr_pkg::t_div_rsp o_rsp
);
    localparam int NW = dtr_pkg::NW;
    localparam int EW = dtr_pkg::EW;
    localparam int QW = dtr_pkg::QW;
    localparam int SW = $clog2(QW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [NW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_dsh, n_dsh;
    logic [QW-1:0] r_quo, n_quo;
    logic [SW-1:0] r_cnt, n_cnt;
    logic          r_neg, n_neg;
    logic [NW-1:0] w_num_abs;
    logic [EW-1:0] w_den_abs;
    logic          w_ge;

    assign w_num_abs = i_req.num[NW-1] ? NW'(-i_req.num) : NW'(i_req.num);
    assign w_den_abs = i_req.den[EW-1] ? EW'(-i_req.den) : EW'(i_req.den);
    assign w_ge = r_rem >= r_dsh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem = r_rem;
        n_dsh = r_dsh;
        n_quo = r_quo;
        n_cnt = r_cnt;
        n_neg = r_neg;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_rem = w_num_abs;
            n_dsh = NW'(w_den_abs) << (QW - 1);
            n_quo = '0;
            n_cnt = SW'(QW);
            n_neg = i_req.num[NW-1] ^ i_req.den[EW-1];
        end else if (r_busy) begin
            if (w_ge) begin
                n_rem = r_rem - r_dsh;
            end
            n_quo = {r_quo[QW-2:0], w_ge};
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == SW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
endmodule

// ===== rtl/core/depth_tested_triangle_rasterizer.sv =====
// top level of the depth tested triangle rasterizer
// usage:
// - input channel i_valid/o_ready carries one transaction per item: a draw,
//   a pixel read, a depth write or no operation, selected by i_func
// - output channel o_valid/i_ready returns exactly one result per item
// - i_cfg_we/i_cfg_wdata set centered_mode; user must keep to idle, unchecked
// - the stores live in one ram of WIDTH*HEIGHT words; after reset a clearing
//   pass writes zero to every word while o_ready stays low
// - a read steps ST_RD, ST_RDW, ST_OUT; a depth write ST_WR, ST_OUT
// - a draw runs setup states ST_BOX, ST_AREA, ST_EA, ST_EB, ST_EG, ST_ORG,
//   then scans the bounding box; a pixel outside the triangle or the store is
//   skipped and one inside is read, multiplied, divided and written back,
//   after which the result goes to the output register
// - one item is in work at a time; a finished result waits in the output
//   register while the next item is accepted, and the block holds its next
//   result until the receiver takes the waiting one
module depth_tested_triangle_rasterizer #(
    parameter int WIDTH  = 64,
    parameter int HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic signed [10:0] i_ax,
    input  logic signed [10:0] i_ay,
    input  logic signed [15:0] i_az,
    input  logic signed [10:0] i_bx,
    input  logic signed [10:0] i_by,
    input  logic signed [15:0] i_bz,
    input  logic signed [10:0] i_cx,
    input  logic signed [10:0] i_cy,
    input  logic signed [15:0] i_cz,
    input  logic [11:0]        i_pixel_index,
    input  logic signed [15:0] i_depth_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_pixel_brightness,
    output logic signed [15:0] o_pixel_depth,
    output logic [12:0]        o_pixels_written
);
    localparam int CW = dtr_pkg::CW;
    localparam int DW = dtr_pkg::DW;
    localparam int EW = dtr_pkg::EW;
    localparam int ZW = dtr_pkg::ZW;
    localparam int PW = dtr_pkg::PW;
    localparam int NW = dtr_pkg::NW;
    localparam int QW = dtr_pkg::QW;
    localparam int BW = dtr_pkg::BW;
    localparam int CNTW = dtr_pkg::CNTW;
    localparam int VW = dtr_pkg::VW;
    localparam int STORE = WIDTH * HEIGHT;
    localparam int AW = $clog2(STORE);
    localparam int LW = CW + $clog2(WIDTH) + 2;
    localparam int RW = BW + ZW;

    dtr_pkg::t_state r_state, n_state;

    logic                   r_cm, n_cm;
    logic [11:0]            r_pidx, n_pidx;
    logic signed [ZW-1:0]   r_dval, n_dval;
    logic signed [CW-1:0]   r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic signed [CW-1:0]   r_x2, n_x2, r_y2, n_y2;
    logic signed [ZW-1:0]   r_z0, n_z0, r_z1, n_z1, r_z2, n_z2;
    logic signed [CW-1:0]   r_minx, n_minx, r_maxx, n_maxx, r_miny, n_miny;
    logic signed [CW-1:0]   r_maxy, n_maxy, r_x, n_x, r_y, n_y;
    logic signed [DW-1:0]   r_dx01, n_dx01, r_dy01, n_dy01, r_dx12, n_dx12;
    logic signed [DW-1:0]   r_dy12, n_dy12, r_dx20, n_dx20, r_dy20, n_dy20;
    logic signed [EW-1:0]   r_area, n_area;
    logic signed [EW-1:0]   r_ea, n_ea, r_eb, n_eb, r_eg, n_eg;
    logic signed [EW-1:0]   r_ea_row, n_ea_row, r_eb_row, n_eb_row;
    logic signed [EW-1:0]   r_eg_row, n_eg_row;
    logic signed [LW-1:0]   r_lin, n_lin, r_lin_row, n_lin_row;
    logic signed [NW-1:0]   r_num, n_num;
    logic [1:0]             r_k, n_k;
    logic [CNTW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]          r_clr, n_clr;
    logic [BW-1:0]          r_res_b, n_res_b;
    logic signed [ZW-1:0]   r_res_d, n_res_d;
    logic [CNTW-1:0]        r_res_n, n_res_n;
    logic                   r_out_valid, n_out_valid;
    logic [BW-1:0]          r_out_b, n_out_b;
    logic signed [ZW-1:0]   r_out_d, n_out_d;
    logic [CNTW-1:0]        r_out_n, n_out_n;

    logic                   w_ram_we;
    logic [AW-1:0]          w_ram_addr;
    logic [RW-1:0]          w_ram_wdata, w_ram_rdata;
    dtr_pkg::t_div_req      w_div_req;
    dtr_pkg::t_div_rsp      w_div_rsp;
    logic signed [CW-1:0]   w_cx0, w_cy0, w_cx1, w_cy1, w_cx2, w_cy2;
    logic [31:0]            w_pidx32;
    logic                   w_pidx_ok;
    logic                   w_inside, w_lin_ok, w_adv;
    logic signed [ZW-1:0]   w_mz;
    logic signed [EW-1:0]   w_me;
    logic signed [PW-1:0]   w_prod;
    logic signed [ZW-1:0]   w_zs;
    logic signed [VW-1:0]   w_v;
    logic [BW-1:0]          w_bright;
    logic signed [ZW-1:0]   w_old;

    function automatic logic signed [CW-1:0] f_min3(logic signed [CW-1:0] a,
            logic signed [CW-1:0] b, logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] f_max3(logic signed [CW-1:0] a,
            logic signed [CW-1:0] b, logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] f_mapx(logic signed [10:0] v, logic cm);
        return cm ? CW'(v) + CW'(WIDTH / 2) : CW'(v);
    endfunction

    function automatic logic signed [CW-1:0] f_mapy(logic signed [10:0] v, logic cm);
        return cm ? CW'(HEIGHT / 2) - CW'(v) : CW'(v);
    endfunction

    assign w_cx0 = f_mapx(i_ax, r_cm);
    assign w_cy0 = f_mapy(i_ay, r_cm);
    assign w_cx1 = f_mapx(i_bx, r_cm);
    assign w_cy1 = f_mapy(i_by, r_cm);
    assign w_cx2 = f_mapx(i_cx, r_cm);
    assign w_cy2 = f_mapy(i_cy, r_cm);

    assign w_pidx32 = 32'(r_pidx);
    assign w_pidx_ok = w_pidx32 < 32'(STORE);

    assign w_inside = (r_ea >= 0 && r_eb >= 0 && r_eg >= 0) ||
                      (r_ea <= 0 && r_eb <= 0 && r_eg <= 0);
    assign w_lin_ok = (r_lin >= 0) && (r_lin < LW'(STORE));

    always_comb begin
        unique case (r_k)
            2'd0:    begin w_mz = r_z0; w_me = r_eb; end
            2'd1:    begin w_mz = r_z1; w_me = r_eg; end
            default: begin w_mz = r_z2; w_me = r_ea; end
        endcase
    end
    assign w_prod = PW'(w_mz) * PW'(w_me);

    always_comb begin
        if (w_div_rsp.quo > (QW + 1)'(32767)) begin
            w_zs = 16'sh7fff;
        end else if (w_div_rsp.quo < -(QW + 1)'(32768)) begin
            w_zs = -16'sh8000;
        end else begin
            w_zs = w_div_rsp.quo[ZW-1:0];
        end
    end

    assign w_v = VW'(w_zs) * VW'(dtr_pkg::BRIGHT_GAIN) - VW'(dtr_pkg::BRIGHT_OFS);
    always_comb begin
        if (w_v <= 0) begin
            w_bright = '0;
        end else if (|w_v[VW-1:dtr_pkg::FRAC_BITS+BW]) begin
            w_bright = BW'(dtr_pkg::BRIGHT_GAIN);
        end else begin
            w_bright = w_v[dtr_pkg::FRAC_BITS+BW-1:dtr_pkg::FRAC_BITS];
        end
    end
    assign w_old = w_ram_rdata[ZW-1:0];

    always_comb begin
        n_state = r_state;
        n_cm = i_cfg_we ? i_cfg_wdata : r_cm;
        n_pidx = r_pidx;
        n_dval = r_dval;
        n_x0 = r_x0; n_y0 = r_y0; n_x1 = r_x1; n_y1 = r_y1; n_x2 = r_x2; n_y2 = r_y2;
        n_z0 = r_z0; n_z1 = r_z1; n_z2 = r_z2;
        n_minx = r_minx; n_maxx = r_maxx; n_miny = r_miny; n_maxy = r_maxy;
        n_x = r_x; n_y = r_y;
        n_dx01 = r_dx01; n_dy01 = r_dy01; n_dx12 = r_dx12;
        n_dy12 = r_dy12; n_dx20 = r_dx20; n_dy20 = r_dy20;
        n_area = r_area;
        n_ea = r_ea; n_eb = r_eb; n_eg = r_eg;
        n_ea_row = r_ea_row; n_eb_row = r_eb_row; n_eg_row = r_eg_row;
        n_lin = r_lin; n_lin_row = r_lin_row;
        n_num = r_num; n_k = r_k; n_cnt = r_cnt; n_clr = r_clr;
        n_res_b = r_res_b; n_res_d = r_res_d; n_res_n = r_res_n;
        n_out_valid = r_out_valid && !i_ready;
        n_out_b = r_out_b; n_out_d = r_out_d; n_out_n = r_out_n;
        o_ready = 1'b0;
        w_ram_we = 1'b0;
        w_ram_addr = r_lin[AW-1:0];
        w_ram_wdata = '0;
        w_div_req.start = 1'b0;
        w_div_req.num = r_num;
        w_div_req.den = r_area;
        w_adv = 1'b0;

        unique case (r_state)
            dtr_pkg::ST_CLEAR: begin
                w_ram_we = 1'b1;
                w_ram_addr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(STORE - 1)) begin
                    n_state = dtr_pkg::ST_IDLE;
                end
            end
            dtr_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_pidx = i_pixel_index;
                    n_dval = i_depth_value;
                    n_x0 = w_cx0; n_y0 = w_cy0; n_x1 = w_cx1;
                    n_y1 = w_cy1; n_x2 = w_cx2; n_y2 = w_cy2;
                    n_z0 = i_az; n_z1 = i_bz; n_z2 = i_cz;
                    n_res_b = '0; n_res_d = '0; n_res_n = '0;
                    unique case (i_func)
                        dtr_pkg::FUNC_DRAW:   n_state = dtr_pkg::ST_BOX;
                        dtr_pkg::FUNC_READ:   n_state = dtr_pkg::ST_RD;
                        dtr_pkg::FUNC_WDEPTH: n_state = dtr_pkg::ST_WR;
                        dtr_pkg::FUNC_NONE:   n_state = dtr_pkg::ST_OUT;
                    endcase
                end
            end
            dtr_pkg::ST_BOX: begin
                n_minx = f_min3(r_x0, r_x1, r_x2);
                n_maxx = f_max3(r_x0, r_x1, r_x2);
                n_miny = f_min3(r_y0, r_y1, r_y2);
                n_maxy = f_max3(r_y0, r_y1, r_y2);
                n_dx01 = DW'(r_x1) - DW'(r_x0);
                n_dy01 = DW'(r_y1) - DW'(r_y0);
                n_dx12 = DW'(r_x2) - DW'(r_x1);
                n_dy12 = DW'(r_y2) - DW'(r_y1);
                n_dx20 = DW'(r_x0) - DW'(r_x2);
                n_dy20 = DW'(r_y0) - DW'(r_y2);
                n_state = dtr_pkg::ST_AREA;
            end
            dtr_pkg::ST_AREA: begin
                n_area = EW'(r_dy20) * EW'(r_dx01) - EW'(r_dx20) * EW'(r_dy01);
                n_state = dtr_pkg::ST_EA;
            end
            dtr_pkg::ST_EA: begin
                n_ea = EW'(DW'(r_minx) - DW'(r_x0)) * EW'(r_dy01)
                     - EW'(DW'(r_miny) - DW'(r_y0)) * EW'(r_dx01);
                n_ea_row = n_ea;
                n_state = dtr_pkg::ST_EB;
            end
            dtr_pkg::ST_EB: begin
                n_eb = EW'(DW'(r_minx) - DW'(r_x1)) * EW'(r_dy12)
                     - EW'(DW'(r_miny) - DW'(r_y1)) * EW'(r_dx12);
                n_eb_row = n_eb;
                n_state = dtr_pkg::ST_EG;
            end
            dtr_pkg::ST_EG: begin
                n_eg = EW'(DW'(r_minx) - DW'(r_x2)) * EW'(r_dy20)
                     - EW'(DW'(r_miny) - DW'(r_y2)) * EW'(r_dx20);
                n_eg_row = n_eg;
                n_state = dtr_pkg::ST_ORG;
            end
            dtr_pkg::ST_ORG: begin
                n_lin_row = LW'(r_miny) * LW'(WIDTH) + LW'(r_minx);
                n_lin = n_lin_row;
                n_x = r_minx;
                n_y = r_miny;
                n_cnt = '0;
                n_state = (r_area == 0) ? dtr_pkg::ST_OUT : dtr_pkg::ST_SCAN;
            end
            dtr_pkg::ST_SCAN: begin
                if (w_inside && w_lin_ok) begin
                    n_k = 2'd0;
                    n_num = '0;
                    n_state = dtr_pkg::ST_MUL;
                end else begin
                    w_adv = 1'b1;
                end
            end
            dtr_pkg::ST_MUL: begin
                n_num = r_num + NW'(w_prod);
                n_k = r_k + 1'b1;
                if (r_k == 2'd2) begin
                    n_state = dtr_pkg::ST_DIV;
                end
            end
            dtr_pkg::ST_DIV: begin
                w_div_req.start = (r_k == 2'd3);
                n_k = 2'd0;
                if (w_div_rsp.done && r_k == 2'd0) begin
                    n_state = dtr_pkg::ST_WB;
                end
            end
            dtr_pkg::ST_WB: begin
                if (w_old < w_zs) begin
                    w_ram_we = 1'b1;
                    w_ram_wdata = {w_bright, w_zs};
                    if (r_cnt != dtr_pkg::CNT_MAX) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                w_adv = 1'b1;
            end
            dtr_pkg::ST_RD: begin
                w_ram_addr = w_pidx32[AW-1:0];
                n_state = dtr_pkg::ST_RDW;
            end
            dtr_pkg::ST_RDW: begin
                w_ram_addr = w_pidx32[AW-1:0];
                if (w_pidx_ok) begin
                    n_res_b = w_ram_rdata[RW-1:ZW];
                    n_res_d = w_ram_rdata[ZW-1:0];
                end
                n_state = dtr_pkg::ST_OUT;
            end
            dtr_pkg::ST_WR: begin
                w_ram_addr = w_pidx32[AW-1:0];
                w_ram_we = w_pidx_ok;
                w_ram_wdata = {BW'(0), r_dval};
                n_state = dtr_pkg::ST_OUT;
            end
            dtr_pkg::ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_b = r_res_b;
                    n_out_d = r_res_d;
                    n_out_n = r_res_n;
                    n_state = dtr_pkg::ST_IDLE;
                end
            end
        endcase

        if (w_adv) begin
            if (r_x == r_maxx) begin
                if (r_y == r_maxy) begin
                    n_res_n = n_cnt;
                    n_state = dtr_pkg::ST_OUT;
                end else begin
                    n_y = r_y + 1'b1;
                    n_x = r_minx;
                    n_ea_row = r_ea_row - EW'(r_dx01);
                    n_eb_row = r_eb_row - EW'(r_dx12);
                    n_eg_row = r_eg_row - EW'(r_dx20);
                    n_ea = n_ea_row;
                    n_eb = n_eb_row;
                    n_eg = n_eg_row;
                    n_lin_row = r_lin_row + LW'(WIDTH);
                    n_lin = n_lin_row;
                    n_state = dtr_pkg::ST_SCAN;
                end
            end else begin
                n_x = r_x + 1'b1;
                n_ea = r_ea + EW'(r_dy01);
                n_eb = r_eb + EW'(r_dy12);
                n_eg = r_eg + EW'(r_dy20);
                n_lin = r_lin + 1'b1;
                n_state = dtr_pkg::ST_SCAN;
            end
        end
    end

    // the divider start is issued in the cycle after the last product lands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtr_pkg::ST_CLEAR;
            r_cm <= 1'b0;
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cm <= n_cm;
            r_clr <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_pidx <= n_pidx; r_dval <= n_dval;
        r_x0 <= n_x0; r_y0 <= n_y0; r_x1 <= n_x1; r_y1 <= n_y1;
        r_x2 <= n_x2; r_y2 <= n_y2;
        r_z0 <= n_z0; r_z1 <= n_z1; r_z2 <= n_z2;
        r_minx <= n_minx; r_maxx <= n_maxx; r_miny <= n_miny; r_maxy <= n_maxy;
        r_x <= n_x; r_y <= n_y;
        r_dx01 <= n_dx01; r_dy01 <= n_dy01; r_dx12 <= n_dx12;
        r_dy12 <= n_dy12; r_dx20 <= n_dx20; r_dy20 <= n_dy20;
        r_area <= n_area;
        r_ea <= n_ea; r_eb <= n_eb; r_eg <= n_eg;
        r_ea_row <= n_ea_row; r_eb_row <= n_eb_row; r_eg_row <= n_eg_row;
        r_lin <= n_lin; r_lin_row <= n_lin_row;
        r_num <= n_num; r_k <= n_k; r_cnt <= n_cnt;
        r_res_b <= n_res_b; r_res_d <= n_res_d; r_res_n <= n_res_n;
        r_out_b <= n_out_b; r_out_d <= n_out_d; r_out_n <= n_out_n;
    end

    dtr_ram #(
        .DATA_W (RW),
        .DEPTH  (STORE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    dtr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_valid = r_out_valid;
    assign o_pixel_brightness = r_out_b;
    assign o_pixel_depth = r_out_d;
    assign o_pixels_written = r_out_n;
endmodule

// ===== rtl/core/dtr_checker.sv =====
// port level checker for the depth tested triangle rasterizer, with bind
module dtr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [7:0]         o_pixel_brightness,
    input logic signed [15:0] o_pixel_depth,
    input logic [12:0]        o_pixels_written
);
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("outputs active right after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transaction accepted while busy");

    a_draw_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixels_written != 13'd0 |->
            o_pixel_brightness == 8'd0 && o_pixel_depth == 16'sd0)
        else $error("draw result carries pixel data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixels_written))
        else $error("stalled result dropped or changed");
endmodule

bind depth_tested_triangle_rasterizer dtr_checker u_dtr_checker (.*);

// ===== sim/tb.sv =====
// testbench of the depth tested triangle rasterizer: scoreboard predicts every result
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = 64;
    localparam int HEIGHT = 64;
    localparam int STORE = WIDTH * HEIGHT;
    localparam int STALL_LIMIT = 400000;

    typedef struct {
        logic [1:0] func;
        logic signed [10:0] ax, ay, bx, by, cx, cy;
        logic signed [15:0] az, bz, cz;
        logic [11:0] pixel_index;
        logic signed [15:0] depth_value;
    } t_item;

    typedef struct {
        logic [7:0] brightness;
        logic signed [15:0] depth;
        logic [12:0] written;
    } t_pixel_result;

    class raster_scoreboard;
        bit [7:0] bright_mem[STORE];
        bit signed [15:0] depth_mem[STORE];
        bit centered;
        t_pixel_result expected_q[$];
        int errors;

        function longint edge_fn(longint px, longint py, longint dx, longint dy);
            return px * dy - py * dx;
        endfunction

        function int unsigned draw_tri(longint x0, longint y0, longint z0, longint x1,
                                       longint y1, longint z1, longint x2, longint y2,
                                       longint z2);
            longint area, minx, maxx, miny, maxy, base, lo, hi, ea, eb, eg, z, v;
            int unsigned count;
            area = edge_fn(x2 - x0, y2 - y0, x1 - x0, y1 - y0);
            count = 0;
            if (area == 0) return 0;
            minx = x0; maxx = x0; miny = y0; maxy = y0;
            if (x1 < minx) minx = x1;
            if (x2 < minx) minx = x2;
            if (x1 > maxx) maxx = x1;
            if (x2 > maxx) maxx = x2;
            if (y1 < miny) miny = y1;
            if (y2 < miny) miny = y2;
            if (y1 > maxy) maxy = y1;
            if (y2 > maxy) maxy = y2;
            for (longint y = miny; y <= maxy; y++) begin
                base = y * WIDTH;
                lo = (minx < -base) ? -base : minx;
                hi = (maxx > STORE - 1 - base) ? STORE - 1 - base : maxx;
                for (longint x = lo; x <= hi; x++) begin
                    ea = edge_fn(x - x0, y - y0, x1 - x0, y1 - y0);
                    eb = edge_fn(x - x1, y - y1, x2 - x1, y2 - y1);
                    eg = edge_fn(x - x2, y - y2, x0 - x2, y0 - y2);
                    if (!((ea >= 0 && eb >= 0 && eg >= 0) || (ea <= 0 && eb <= 0 && eg <= 0)))
                        continue;
                    z = (z0 * eb + z1 * eg + z2 * ea) / area;
                    if (z > 32767) z = 32767;
                    if (z < -32768) z = -32768;
                    if (longint'(depth_mem[base + x]) < z) begin
                        depth_mem[base + x] = z[15:0];
                        v = 255 * z - 20 * 16384;
                        if (v <= 0) v = 0;
                        else begin
                            v = v / 16384;
                            if (v > 255) v = 255;
                        end
                        bright_mem[base + x] = v[7:0];
                        if (count < 8191) count++;
                    end
                end
            end
            return count;
        endfunction

        function void note_item(t_item it);
            t_pixel_result r;
            longint x0, y0, x1, y1, x2, y2;
            int unsigned n;
            r = '{8'd0, 16'sd0, 13'd0};
            if (it.func == dtr_pkg::FUNC_DRAW) begin
                x0 = it.ax; y0 = it.ay; x1 = it.bx; y1 = it.by; x2 = it.cx; y2 = it.cy;
                if (centered) begin
                    x0 += WIDTH / 2; x1 += WIDTH / 2; x2 += WIDTH / 2;
                    y0 = HEIGHT / 2 - y0; y1 = HEIGHT / 2 - y1; y2 = HEIGHT / 2 - y2;
                end
                n = draw_tri(x0, y0, it.az, x1, y1, it.bz, x2, y2, it.cz);
                r.written = n[12:0];
            end else if (it.func == dtr_pkg::FUNC_READ) begin
                r.brightness = bright_mem[it.pixel_index];
                r.depth = depth_mem[it.pixel_index];
            end else if (it.func == dtr_pkg::FUNC_WDEPTH) begin
                depth_mem[it.pixel_index] = it.depth_value;
                bright_mem[it.pixel_index] = 8'd0;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_pixel_result got);
            t_pixel_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%t: unexpected result b=%0d z=%0d n=%0d", $realtime,
                         got.brightness, got.depth, got.written);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.brightness !== exp_r.brightness) begin
                $display("%t: brightness expected %0d actual %0d", $realtime,
                         exp_r.brightness, got.brightness);
                errors++;
            end
            if (got.depth !== exp_r.depth) begin
                $display("%t: depth expected %0d actual %0d", $realtime, exp_r.depth, got.depth);
                errors++;
            end
            if (got.written !== exp_r.written) begin
                $display("%t: pixels written expected %0d actual %0d", $realtime,
                         exp_r.written, got.written);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_func = '0;
    logic signed [10:0] i_ax = '0, i_ay = '0, i_bx = '0, i_by = '0, i_cx = '0, i_cy = '0;
    logic signed [15:0] i_az = '0, i_bz = '0, i_cz = '0, i_depth_value = '0;
    logic [11:0] i_pixel_index = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [7:0] o_pixel_brightness;
    logic signed [15:0] o_pixel_depth;
    logic [12:0] o_pixels_written;

    raster_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    depth_tested_triangle_rasterizer #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver side with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{o_pixel_brightness, o_pixel_depth, o_pixels_written});
        if (hold_req && hold_cnt == 0) hold_cnt = 600;
        if (hold_cnt > 0) begin
            hold_cnt--;
            if (hold_cnt == 0) hold_req = 1'b0;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic send_item(t_item it);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func <= it.func;
        i_ax <= it.ax; i_ay <= it.ay; i_az <= it.az;
        i_bx <= it.bx; i_by <= it.by; i_bz <= it.bz;
        i_cx <= it.cx; i_cy <= it.cy; i_cz <= it.cz;
        i_pixel_index <= it.pixel_index;
        i_depth_value <= it.depth_value;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(it);
    endtask

    task automatic set_centered(bit v);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.centered = v;
    endtask

    function automatic t_item make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                       int x2, int y2, int z2);
        t_item it;
        it = '{dtr_pkg::FUNC_DRAW, 11'(x0), 11'(y0), 11'(x1), 11'(y1), 11'(x2), 11'(y2),
               16'(z0), 16'(z1), 16'(z2), 12'($urandom), 16'($urandom)};
        return it;
    endfunction

    function automatic t_item make_op(logic [1:0] f, int idx, int d);
        t_item it;
        it = '{f, 11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom),
               11'($urandom), 11'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               12'(idx), 16'(d)};
        return it;
    endfunction

    function automatic t_item random_item();
        int sel, bx0, by0, zlo;
        sel = $urandom_range(99);
        bx0 = sb.centered ? $urandom_range(0, 80) - 40 : $urandom_range(0, 80) - 8;
        by0 = sb.centered ? $urandom_range(0, 80) - 40 : $urandom_range(0, 80) - 8;
        zlo = $urandom_range(0, 32767);
        if (sel < 40)
            return make_tri(bx0, by0, ($urandom_range(1) ? zlo : $urandom),
                            bx0 + $urandom_range(0, 14) - 7, by0 + $urandom_range(0, 14) - 7,
                            ($urandom_range(1) ? zlo + $urandom_range(0, 300) : $urandom),
                            bx0 + $urandom_range(0, 14) - 7, by0 + $urandom_range(0, 14) - 7,
                            $urandom_range(0, 32767));
        else if (sel < 75)
            return make_op(dtr_pkg::FUNC_READ,
                           $urandom_range(1) ? $urandom_range(0, 1500) : $urandom, 0);
        else if (sel < 95)
            return make_op(dtr_pkg::FUNC_WDEPTH, $urandom, $urandom);
        else
            return make_op(dtr_pkg::FUNC_NONE, $urandom, $urandom);
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_centered(1'b0);
        // directed part
        send_item(make_tri(0, 0, 8192, 63, 0, 8192, 0, 63, 8192));
        send_item(make_op(dtr_pkg::FUNC_READ, 0, 0));
        send_item(make_op(dtr_pkg::FUNC_READ, 100, 0));
        send_item(make_op(dtr_pkg::FUNC_WDEPTH, 4095, -32768));
        send_item(make_op(dtr_pkg::FUNC_READ, 4095, 0));
        send_item(make_op(dtr_pkg::FUNC_WDEPTH, 5, 32767));
        send_item(make_op(dtr_pkg::FUNC_READ, 5, 0));
        send_item(make_tri(-1024, -1024, -32768, 1023, 1023, 32767, 0, 0, 100));
        send_item(make_tri(-1024, 0, 16384, 1023, 0, 16384, 1023, 1, 32767));
        send_item(make_tri(0, -1024, 20000, 0, 1023, 20000, 1, 1023, 30000));
        send_item(make_tri(10, 40, 1300, 30, 60, 1290, 10, 60, 1280));
        send_item(make_tri(10, 60, 32767, 30, 60, 32767, 10, 40, 32767));
        send_item(make_op(dtr_pkg::FUNC_READ, 60 * 64 + 12, 0));
        send_item(make_op(dtr_pkg::FUNC_READ, 1000, 0));
        send_item(make_op(dtr_pkg::FUNC_NONE, 4095, -1));
        send_item(make_op(dtr_pkg::FUNC_READ, 4095, 0));
        set_centered(1'b1);
        send_item(make_tri(-32, 32, 16384, 31, 32, 16384, 0, -31, 16384));
        send_item(make_tri(-5, -5, 12000, 5, -5, 12000, 0, 5, 12000));
        send_item(make_op(dtr_pkg::FUNC_READ, 32 * 64 + 32, 0));
        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2 || ph == 4) set_centered(ph == 2 ? 1'b0 : 1'b1);
            if (ph == 5) set_centered(1'b0);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 73; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 73; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (ph == 3) hold_req = 1'b1;
            for (int k = 0; k < 22; k++) send_item(random_item());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
